/* rtl/lrc_pkg.sv */
package lrc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int MAX_PASSES     = 4;

    localparam logic [3:0] OC_LEFT  = 4'h1;
    localparam logic [3:0] OC_RIGHT = 4'h2;
    localparam logic [3:0] OC_BELOW = 4'h4;
    localparam logic [3:0] OC_ABOVE = 4'h8;
    localparam logic [3:0] OC_ALL   = 4'hf;

    typedef struct packed {
        logic done;
        logic neg;
    } mdu_stat_t;

endpackage

/* rtl/lrc_mdu.sv */
module lrc_mdu #(
    parameter int W = lrc_pkg::COORD_BITS_DEF + lrc_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W:0]   op_a,
    input  logic signed [W:0]   op_b,
    input  logic signed [W:0]   op_c,
    output lrc_pkg::mdu_stat_t  stat,
    output logic [W-1:0]        quot
);

    localparam int CW = $clog2(W);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_MUL  = 3'b010,
        M_DIV  = 3'b100
    } mstate_t;

    mstate_t         state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic            neg_reg, neg_next;
    logic [W-1:0]    mcand_reg, mcand_next;
    logic [W-1:0]    dvs_reg, dvs_next;
    logic [W:0]      hi_reg, hi_next;
    logic [W-1:0]    lo_reg, lo_next;

    logic [W-1:0]    abs_a, abs_b, abs_c;
    logic [W:0]      add_a;
    logic [W+1:0]    add_b;
    logic            add_cin;
    logic [W+1:0]    sum;
    logic            no_borrow;

    // one shared adder: add for shift-add multiply, subtract for restoring divide
    always_comb
    begin
        abs_a = W'(op_a[W] ? -op_a : op_a);
        abs_b = W'(op_b[W] ? -op_b : op_b);
        abs_c = W'(op_c[W] ? -op_c : op_c);

        if (state_reg == M_DIV)
        begin
            add_a   = {hi_reg[W-1:0], lo_reg[W-1]};
            add_b   = ~{2'b00, dvs_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_a   = hi_reg;
            add_b   = lo_reg[0] ? {2'b00, mcand_reg} : '0;
            add_cin = 1'b0;
        end
        sum       = {1'b0, add_a} + add_b + (W+2)'(add_cin);
        no_borrow = ~sum[W+1];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        mcand_next = mcand_reg;
        dvs_next   = dvs_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    mcand_next = abs_a;
                    lo_next    = abs_b;
                    dvs_next   = abs_c;
                    hi_next    = '0;
                    neg_next   = op_a[W] ^ op_b[W] ^ op_c[W];
                    cnt_next   = CW'(W - 1);
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                hi_next = sum[W+1:1];
                lo_next = {sum[0], lo_reg[W-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CW'(W - 1);
                    state_next = M_DIV;
                end
            end
            M_DIV:
            begin
                hi_next  = no_borrow ? sum[W:0] : add_a;
                lo_next  = {lo_reg[W-2:0], no_borrow};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mcand_reg <= mcand_next;
        dvs_reg   <= dvs_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign stat.done = done_reg;
    assign stat.neg  = neg_reg;
    assign quot      = lo_reg;

endmodule

/* rtl/line_rectangle_clipper.sv */
// Cohen-Sutherland clipper of a segment against an axis-aligned rectangle.
// Slave channel: one word per segment; the rectangle travels with it.
// Master channel: one word per segment; tuser is 1 when any part of the
// segment touches the rectangle, and the clipped endpoints are in tdata
// (all zero on reject). Coordinates are worked in fixed point with
// FRAC_BITS fraction bits and truncated toward zero on the way out.
// Each clip pass runs one shared serial multiply/divide unit: a shift-add
// multiply of W = COORD_BITS + FRAC_BITS steps, then a restoring divide of
// W steps, sequenced by the ST_SETUP and ST_WAIT states. A segment takes
// 0 to 4 clip passes before its result is written. The block takes one
// segment at a time: s_tready is high only while idle, so a segment
// occupies the block until its result is written. A finished result sits
// in the output register, so a new segment is taken while it waits; if the
// receiver still stalls when the next one is done, that result waits in
// the sequencer.
// Reset clears the sequencer and the output valid; nothing else is needed.
module line_rectangle_clipper #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lrc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // start_x, start_y, end_x, end_y, rect_left, rect_top, rect_right, rect_bottom
    input  logic [8*COORD_BITS-1:0]                s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y, zero fill; the two endpoints may come out swapped
    output logic [((4*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    // accepted
    output logic                                   m_tuser
);

    localparam int C     = COORD_BITS;
    localparam int W     = COORD_BITS + FRAC_BITS;
    localparam int OUT_W = ((4*COORD_BITS+7)/8)*8;
    localparam int PW    = $clog2(lrc_pkg::MAX_PASSES + 1);
    localparam logic [W-1:0] BIAS = W'((64'd1 << FRAC_BITS) - 64'd1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CODE  = 5'b00010,
        ST_SETUP = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [PW-1:0]         pass_reg, pass_next;
    logic                  acc_reg, acc_next;
    logic [3:0]            oc_reg, oc_next;
    logic                  ymode_reg, ymode_next;
    logic signed [W-1:0]   edge_reg, edge_next;
    logic signed [W-1:0]   x1_reg, x1_next, y1_reg, y1_next;
    logic signed [W-1:0]   x2_reg, x2_next, y2_reg, y2_next;
    logic signed [W-1:0]   left_reg, left_next, top_reg, top_next;
    logic signed [W-1:0]   right_reg, right_next, bottom_reg, bottom_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic [3:0]            c1, c2;
    logic                  sel_y;
    logic signed [W-1:0]   sel_edge, u1, u2, v1, v2;
    logic signed [W:0]     op_a, op_b, op_c;
    logic                  mdu_start;
    lrc_pkg::mdu_stat_t    mdu_stat;
    logic [W-1:0]          quot;
    logic signed [W-1:0]   moved;
    logic signed [W-1:0]   moved_base;

    function automatic logic signed [W-1:0] scale(input logic [C-1:0] v);
        logic signed [W-1:0] e;
        e = W'($signed(v));
        return e <<< FRAC_BITS;
    endfunction

    function automatic logic [C-1:0] unscale(input logic signed [W-1:0] v);
        logic signed [W-1:0] s;
        logic signed [W-1:0] t;
        s = v + (v[W-1] ? BIAS : '0);
        t = s >>> FRAC_BITS;
        return t[C-1:0];
    endfunction

    function automatic logic [3:0] outcode(
        input logic signed [W-1:0] x,
        input logic signed [W-1:0] y,
        input logic signed [W-1:0] l,
        input logic signed [W-1:0] t,
        input logic signed [W-1:0] r,
        input logic signed [W-1:0] b
    );
        logic [3:0] c;
        c = '0;
        if (x < l) c = c | lrc_pkg::OC_LEFT;
        if (x > r) c = c | lrc_pkg::OC_RIGHT;
        if (y < t) c = c | lrc_pkg::OC_ABOVE;
        if (y > b) c = c | lrc_pkg::OC_BELOW;
        return c;
    endfunction

    lrc_mdu #(
        .W(W)
    ) u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mdu_start),
        .op_a  (op_a),
        .op_b  (op_b),
        .op_c  (op_c),
        .stat  (mdu_stat),
        .quot  (quot)
    );

    always_comb
    begin
        c1 = outcode(x1_reg, y1_reg, left_reg, top_reg, right_reg, bottom_reg);
        c2 = outcode(x2_reg, y2_reg, left_reg, top_reg, right_reg, bottom_reg);

        sel_y = ((oc_reg & (lrc_pkg::OC_ABOVE | lrc_pkg::OC_BELOW)) != '0);
        if ((oc_reg & lrc_pkg::OC_ABOVE) != '0)
            sel_edge = top_reg;
        else if ((oc_reg & lrc_pkg::OC_BELOW) != '0)
            sel_edge = bottom_reg;
        else if ((oc_reg & lrc_pkg::OC_RIGHT) != '0)
            sel_edge = right_reg;
        else
            sel_edge = left_reg;

        u1 = sel_y ? x1_reg : y1_reg;
        u2 = sel_y ? x2_reg : y2_reg;
        v1 = sel_y ? y1_reg : x1_reg;
        v2 = sel_y ? y2_reg : x2_reg;
        op_a = (W+1)'(u2) - (W+1)'(u1);
        op_b = (W+1)'(sel_edge) - (W+1)'(v1);
        op_c = (W+1)'(v2) - (W+1)'(v1);

        // the moved point lies between the endpoints, so W bits hold it
        moved_base = ymode_reg ? x1_reg : y1_reg;
        moved = mdu_stat.neg ? moved_base - quot : moved_base + quot;
    end

    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        acc_next      = acc_reg;
        oc_next       = oc_reg;
        ymode_next    = ymode_reg;
        edge_next     = edge_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        x2_next       = x2_reg;
        y2_next       = y2_reg;
        left_next     = left_reg;
        top_next      = top_reg;
        right_next    = right_reg;
        bottom_next   = bottom_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mdu_start     = 1'b0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x1_next     = scale(s_tdata[0*C +: C]);
                    y1_next     = scale(s_tdata[1*C +: C]);
                    x2_next     = scale(s_tdata[2*C +: C]);
                    y2_next     = scale(s_tdata[3*C +: C]);
                    left_next   = scale(s_tdata[4*C +: C]);
                    top_next    = scale(s_tdata[5*C +: C]);
                    right_next  = scale(s_tdata[6*C +: C]);
                    bottom_next = scale(s_tdata[7*C +: C]);
                    pass_next   = '0;
                    state_next  = ST_CODE;
                end
            end
            ST_CODE:
            begin
                if ((c1 & c2) != '0)
                begin
                    acc_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (c1 == '0 && c2 == '0)
                begin
                    acc_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (pass_reg == PW'(lrc_pkg::MAX_PASSES))
                begin
                    acc_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    // move the outside point into the first slot
                    if ((c1 & lrc_pkg::OC_ALL) == '0)
                    begin
                        x1_next = x2_reg;
                        y1_next = y2_reg;
                        x2_next = x1_reg;
                        y2_next = y1_reg;
                        oc_next = c2;
                    end
                    else
                    begin
                        oc_next = c1;
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                mdu_start  = 1'b1;
                ymode_next = sel_y;
                edge_next  = sel_edge;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mdu_stat.done)
                begin
                    if (ymode_reg)
                    begin
                        x1_next = moved;
                        y1_next = edge_reg;
                    end
                    else
                    begin
                        y1_next = moved;
                        x1_next = edge_reg;
                    end
                    pass_next  = pass_reg + 1'b1;
                    state_next = ST_CODE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = acc_reg;
                    if (acc_reg)
                        m_tdata_next = OUT_W'({unscale(y2_reg), unscale(x2_reg),
                                               unscale(y1_reg), unscale(x1_reg)});
                    else
                        m_tdata_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pass_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        oc_reg      <= oc_next;
        ymode_reg   <= ymode_next;
        edge_reg    <= edge_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        x2_reg      <= x2_next;
        y2_reg      <= y2_next;
        left_reg    <= left_next;
        top_reg     <= top_next;
        right_reg   <= right_next;
        bottom_reg  <= bottom_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/lrc_checker.sv */
module lrc_checker #(
    parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((4*COORD_BITS+7)/8)*8-1:0]   m_tdata,
    input logic                                m_tuser
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");

    // a rejected segment carries zero coordinates
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("rejected word has nonzero data");

    // one segment at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a new result only comes out of a busy cycle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work in progress");

endmodule

bind line_rectangle_clipper lrc_checker #(
    .COORD_BITS(COORD_BITS)
) u_lrc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
